### hw/rtl/bfa_pkg.sv
// Package for the best-fit block allocator: sizes, status codes, table entry type.
// No dependencies.
`default_nettype none
package bfa_pkg;
    localparam int ADDR_W          = 48;
    localparam int SIZE_W          = 25;
    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_HEADER      = 32;
    localparam int DEF_REGION_SIZE = 1048576;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    // one block: offset in region, data size, in-use mark
    typedef struct packed {
        logic [SIZE_W-1:0] off;
        logic [SIZE_W-1:0] size;
        logic              used;
    } t_blk;
    localparam int BLK_W = 2 * SIZE_W + 1;
endpackage
`default_nettype wire

### hw/rtl/bfa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/best_fit_block_allocator.sv
// Top level of the best-fit block allocator: sequencer, shared compare unit, block table.
// Depends on bfa_pkg and bfa_ram.
//
//  channel | dir | handshake                   | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | action (tuser), request_bytes, free_address
//  m_axis  | out | m_axis_tvalid/m_axis_tready | status (tuser), data_address, granted_bytes
//  cfg     | in  | i_cfg_we                    | index 0 region_base, 1 region_size
//
// One word: an accept state, a search pass with a read and a compare state per valid
// slot through the registered RAM read (a free stops one slot past its match), a decide
// state, then a shift pass with a read and a write state per moved slot for a split or
// merge, up to two neighbor reads (read, then check) for a free, a final write and an
// output state. Reset rebuilds the table (slot zero rewritten, count set to one); a
// config write sets the count to one but rewrites slot zero only while idle. The result
// register holds until taken; no new word enters before then.
`default_nettype none
module best_fit_block_allocator #(
    parameter int MAX_BLOCKS   = bfa_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = bfa_pkg::DEF_HEADER
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [47:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // tdata: request_bytes[24:0], free_address[72:25], zero fill to 80
    input  wire logic [79:0] s_axis_tdata,
    // tuser: action
    input  wire logic        s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: data_address[47:0], granted_bytes[72:48], zero fill to 80
    output      logic [79:0] m_axis_tdata,
    // tuser: status
    output      logic [1:0]  m_axis_tuser
);
    localparam int AW = bfa_pkg::ADDR_W;
    localparam int SW = bfa_pkg::SIZE_W;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] RST_RSIZE = SW'(bfa_pkg::DEF_REGION_SIZE);
    localparam logic [SW-1:0] RST_SZ = (RST_RSIZE > HDR) ? RST_RSIZE - HDR : '0;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // issue read of slot r_idx
    localparam logic [3:0] S_CMP   = 4'd2;  // compare read data in shared unit
    localparam logic [3:0] S_DEC   = 4'd3;  // decide after search
    localparam logic [3:0] S_SHRD  = 4'd4;  // shift: read source slot
    localparam logic [3:0] S_SHWR  = 4'd5;  // shift: write destination slot
    localparam logic [3:0] S_FIN   = 4'd6;  // final writes
    localparam logic [3:0] S_NBRD  = 4'd7;  // free: read neighbor
    localparam logic [3:0] S_NBCK  = 4'd8;  // free: check neighbor
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]    r_state;
    logic [AW-1:0] r_base;
    logic [SW-1:0] r_rsize;
    logic [CW-1:0] r_count;
    logic          r_act;
    logic [SW-1:0] r_req;
    logic [AW-1:0] r_fa;
    logic [IW-1:0] r_idx;
    logic          r_found;
    logic [IW-1:0] r_pos;
    bfa_pkg::t_blk r_pblk;
    logic [SW-1:0] r_best;
    // shift/merge bookkeeping
    logic          r_dir;     // 1 shift up (split), 0 shift down (merge)
    logic [IW-1:0] r_stop;
    logic [1:0]    r_phase;   // free: 0 next check, 1 next merge shift, 2 prev check, 3 prev merge shift
    logic [1:0]    r_ost;
    logic [AW-1:0] r_oaddr;
    logic [SW-1:0] r_ogrant;
    logic          r_ovalid;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    bfa_pkg::t_blk wdata, rdata;
    logic [bfa_pkg::BLK_W-1:0] rword;

    bfa_ram #(.WIDTH(bfa_pkg::BLK_W), .DEPTH(MAX_BLOCKS)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rword)
    );
    assign rdata = bfa_pkg::t_blk'(rword);

    // shared unit: one wide subtract/compare on the slot just read
    logic [SW:0]   diff;
    logic          fits, better;
    logic [AW-1:0] daddr;
    assign diff   = {1'b0, rdata.size} - {1'b0, r_req};
    assign fits   = !rdata.used && !diff[SW];
    assign better = !r_found || (diff[SW-1:0] < r_best);
    assign daddr  = r_base + AW'(rdata.off) + AW'(HDR);

    logic          last_idx;
    assign last_idx = ({1'b0, r_idx} + 1'b1) >= (CW+1)'(r_count);

    logic [SW+1:0] need;
    assign need = {2'b0, r_req} + {2'b0, HDR};

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ost;
    assign m_axis_tdata  = {7'd0, r_ogrant, r_oaddr};

    logic [SW-1:0] init_sz;
    assign init_sz = (r_rsize > HDR) ? r_rsize - HDR : '0;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_base <= '0;
            r_rsize <= RST_RSIZE;
            r_count <= CW'(1);
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == bfa_pkg::CFG_BASE) r_base <= i_cfg_wdata;
                else r_rsize <= i_cfg_wdata[SW-1:0];
                r_count <= CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act <= s_axis_tuser;
                        r_req <= s_axis_tdata[SW-1:0];
                        r_fa  <= s_axis_tdata[SW+AW-1:SW];
                        r_idx <= '0;
                        r_found <= 1'b0;
                        if (!s_axis_tuser && s_axis_tdata[SW-1:0] == '0) begin
                            r_ost <= bfa_pkg::ST_ZERO;
                            r_oaddr <= '0;
                            r_ogrant <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (!r_act) begin
                        if (fits && better) begin
                            r_found <= 1'b1;
                            r_best <= diff[SW-1:0];
                            r_pos <= r_idx;
                            r_pblk <= rdata;
                        end
                    end else if (!r_found && rdata.used && daddr == r_fa) begin
                        r_found <= 1'b1;
                        r_pos <= r_idx;
                        r_pblk <= rdata;
                    end
                    if (last_idx || (r_act && r_found)) r_state <= S_DEC;
                    else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DEC: begin
                    if (!r_found) begin
                        r_ost <= r_act ? bfa_pkg::ST_UNKNOWN : bfa_pkg::ST_NOFIT;
                        r_oaddr <= '0;
                        r_ogrant <= '0;
                        r_state <= S_OUT;
                    end else if (!r_act) begin
                        r_ost <= bfa_pkg::ST_OK;
                        r_oaddr <= r_base + AW'(r_pblk.off) + AW'(HDR);
                        r_pblk.used <= 1'b1;
                        if ({2'b0, r_pblk.size} > need && r_count < CW'(MAX_BLOCKS)) begin
                            r_ogrant <= r_req;
                            r_dir <= 1'b1;
                            r_stop <= r_pos + 1'b1;
                            r_idx <= IW'(r_count);   // destination slot
                            r_state <= (IW'(r_count) == r_pos + 1'b1) ? S_FIN : S_SHRD;
                        end else begin
                            r_ogrant <= r_pblk.size;
                            r_dir <= 1'b0;
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_ost <= bfa_pkg::ST_OK;
                        r_oaddr <= r_fa;
                        r_ogrant <= r_pblk.size;
                        r_pblk.used <= 1'b0;
                        r_dir <= 1'b0;
                        r_phase <= 2'd0;
                        r_idx <= r_pos + 1'b1;
                        r_state <= ({1'b0, r_pos} + 1'b1 < (CW+1)'(r_count)) ? S_NBRD : S_NBCK;
                    end
                end
                S_NBRD: r_state <= S_NBCK;
                S_NBCK: begin
                    // neighbor valid when the read was issued within range
                    if (r_phase == 2'd0) begin
                        if (({1'b0, r_pos} + 1'b1 < (CW+1)'(r_count)) && !rdata.used) begin
                            r_pblk.size <= r_pblk.size + rdata.size + HDR;
                            r_dir <= 1'b0;
                            r_idx <= r_pos + 1'b1;
                            r_stop <= IW'(r_count - 1'b1);
                            r_phase <= 2'd1;
                            r_state <= S_SHRD;
                        end else if (r_pos != '0) begin
                            r_phase <= 2'd2;
                            r_idx <= r_pos - 1'b1;
                            r_state <= S_NBRD;
                        end else r_state <= S_FIN;
                    end else begin
                        if (!rdata.used) begin
                            r_pblk.size <= rdata.size + r_pblk.size + HDR;
                            r_pblk.off <= rdata.off;
                            r_pos <= r_pos - 1'b1;
                            r_idx <= r_pos;
                            r_stop <= IW'(r_count - 1'b1);
                            r_phase <= 2'd3;
                            r_state <= S_SHRD;
                        end else r_state <= S_FIN;
                    end
                end
                S_SHRD: begin
                    if (!r_dir && r_idx == r_stop) begin
                        r_count <= r_count - 1'b1;
                        if (r_phase == 2'd1 && r_pos != '0) begin
                            r_phase <= 2'd2;
                            r_idx <= r_pos - 1'b1;
                            r_state <= S_NBRD;
                        end else r_state <= S_FIN;
                    end else r_state <= S_SHWR;
                end
                S_SHWR: begin
                    if (r_dir) begin
                        if (r_idx - 1'b1 == r_stop) r_state <= S_FIN;
                        else r_state <= S_SHRD;
                        r_idx <= r_idx - 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SHRD;
                    end
                end
                S_FIN: begin
                    if (!r_act && r_dir) r_count <= r_count + 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we) r_state <= S_IDLE;
        end
    end

    // RAM port control
    logic [SW-1:0] split_off;
    assign split_off = r_pblk.off + HDR + r_req;
    logic fin_split;
    assign fin_split = (r_state == S_FIN) && !r_act && r_dir;

    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        wdata = rdata;
        raddr = r_idx;
        if (r_state == S_SHRD) begin
            raddr = r_dir ? r_idx - 1'b1 : r_idx + 1'b1;
        end
        if (r_state == S_SHWR) begin
            we = 1'b1;
            waddr = r_idx;
            wdata = rdata;
        end
        if (r_state == S_FIN) begin
            we = 1'b1;
            waddr = r_pos;
            wdata = r_pblk;
            if (fin_split) wdata.size = r_req;
        end
        if (r_state == S_OUT && !r_act && r_dir && r_ost == bfa_pkg::ST_OK) begin
            we = 1'b1;
            waddr = r_pos + 1'b1;
            wdata.off = split_off;
            wdata.size = r_pblk.size - r_req - HDR;
            wdata.used = 1'b0;
        end
        if (r_state == S_DEC && r_act && r_found) begin
            we = 1'b1;
            waddr = r_pos;
            wdata = r_pblk;
            wdata.used = 1'b0;
        end
        if (r_state == S_IDLE && i_cfg_we) begin
            we = 1'b1;
            waddr = '0;
            wdata.off = '0;
            wdata.used = 1'b0;
            wdata.size = (i_cfg_index == bfa_pkg::CFG_SIZE) ?
                ((i_cfg_wdata[SW-1:0] > HDR) ? i_cfg_wdata[SW-1:0] - HDR : '0) :
                init_sz;
        end
        // reset rebuilds slot zero from any state
        if (!i_rst_n) begin
            we = 1'b1;
            waddr = '0;
            wdata.off = '0;
            wdata.size = RST_SZ;
            wdata.used = 1'b0;
        end
    end

    // assertions
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0) else $error("block count zero");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS)) else $error("block count above table depth");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
endmodule
`default_nettype wire

### tb/sv/best_fit_block_allocator_tb.sv
// Self-checking testbench for the best-fit block allocator: random and directed
// allocate/free words checked against an in-bench block table predictor.
// Depends on bfa_pkg and best_fit_block_allocator.
`default_nettype none
module best_fit_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = bfa_pkg::DEF_MAX_BLOCKS;
    localparam int HDR  = bfa_pkg::DEF_HEADER;
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct {
        logic        act;
        logic [24:0] req;
        logic [47:0] addr;
    } t_cmd;

    typedef struct {
        logic [1:0]  st;
        logic [47:0] addr;
        logic [24:0] gb;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [47:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: request_bytes[24:0], free_address[72:25], zero fill to 80
    logic [79:0] s_axis_tdata = '0;
    // tuser: action
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: data_address[47:0], granted_bytes[72:48], zero fill to 80
    logic [79:0] m_axis_tdata;
    // tuser: status
    logic [1:0]  m_axis_tuser;

    best_fit_block_allocator DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted block table
    logic [47:0] rg_base;
    logic [24:0] rg_size;
    logic [24:0] tb_off [NBLK];
    logic [24:0] tb_size[NBLK];
    bit          tb_used[NBLK];
    int          tb_cnt;

    logic [47:0] live_addrs[$];
    t_cmd        pend_cmds[$];
    t_res        exp_results[$];
    int          n_sent = 0;
    int          n_err = 0;
    bit          in_fire = 0;

    function automatic void table_rebuild();
        for (int i = 0; i < NBLK; i++) begin
            tb_off[i] = '0;
            tb_size[i] = '0;
            tb_used[i] = 0;
        end
        tb_size[0] = (rg_size > 25'(HDR)) ? rg_size - 25'(HDR) : '0;
        tb_cnt = 1;
        live_addrs.delete();
    endfunction

    function automatic logic [47:0] slot_addr(int i);
        return rg_base + 48'(tb_off[i]) + 48'(HDR);
    endfunction

    // fold slot i+1 into slot i
    function automatic void merge_up(int i);
        tb_size[i] = tb_size[i] + tb_size[i+1] + 25'(HDR);
        for (int k = i + 1; k + 1 < tb_cnt; k++) begin
            tb_off[k] = tb_off[k+1];
            tb_size[k] = tb_size[k+1];
            tb_used[k] = tb_used[k+1];
        end
        tb_cnt--;
        tb_off[tb_cnt] = '0;
        tb_size[tb_cnt] = '0;
        tb_used[tb_cnt] = 0;
    endfunction

    function automatic t_res alloc_or_free(t_cmd c);
        t_res r;
        int pos;
        longint unsigned best, d;
        r.st = bfa_pkg::ST_OK;
        r.addr = '0;
        r.gb = '0;
        pos = -1;
        best = 0;
        if (c.act == ACT_ALLOC) begin
            if (c.req == 0) begin
                r.st = bfa_pkg::ST_ZERO;
            end else begin
                for (int i = 0; i < tb_cnt; i++) begin
                    if (!tb_used[i] && tb_size[i] >= c.req) begin
                        d = tb_size[i] - c.req;
                        if (pos < 0 || d < best) begin
                            best = d;
                            pos = i;
                        end
                    end
                end
                if (pos < 0) begin
                    r.st = bfa_pkg::ST_NOFIT;
                end else begin
                    tb_used[pos] = 1;
                    if (longint'(tb_size[pos]) > longint'(c.req) + HDR && tb_cnt < NBLK) begin
                        for (int k = tb_cnt; k > pos + 1; k--) begin
                            tb_off[k] = tb_off[k-1];
                            tb_size[k] = tb_size[k-1];
                            tb_used[k] = tb_used[k-1];
                        end
                        tb_off[pos+1] = tb_off[pos] + 25'(HDR) + c.req;
                        tb_size[pos+1] = tb_size[pos] - c.req - 25'(HDR);
                        tb_used[pos+1] = 0;
                        tb_size[pos] = c.req;
                        tb_cnt++;
                    end
                    r.addr = slot_addr(pos);
                    r.gb = tb_size[pos];
                    live_addrs.push_back(r.addr);
                end
            end
        end else begin
            for (int i = 0; i < tb_cnt; i++) begin
                if (pos < 0 && tb_used[i] && slot_addr(i) == c.addr) pos = i;
            end
            if (pos < 0) begin
                r.st = bfa_pkg::ST_UNKNOWN;
            end else begin
                r.addr = c.addr;
                r.gb = tb_size[pos];
                tb_used[pos] = 0;
                if (pos + 1 < tb_cnt && !tb_used[pos+1]) merge_up(pos);
                if (pos > 0 && !tb_used[pos-1]) merge_up(pos - 1);
                foreach (live_addrs[j]) begin
                    if (live_addrs[j] == c.addr) begin
                        live_addrs.delete(j);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic bit idle_now();
        if (n_sent >= 700 && n_sent < 950) return 0;
        return $urandom_range(99) < 36;
    endfunction

    // driver: next word on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (pend_cmds.size() > 0 && !idle_now()) begin
                t_cmd c;
                c = pend_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= c.act;
                s_axis_tdata <= {7'd0, c.addr, c.req};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && !idle_now();
    end

    // monitor: check results, then predict newly accepted words
    always @(posedge i_clk) begin
        t_res got, want;
        t_cmd c;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.st = m_axis_tuser;
            got.addr = m_axis_tdata[47:0];
            got.gb = m_axis_tdata[72:48];
            if (exp_results.size() == 0) begin
                $error("unexpected result word status=%0d", got.st);
                n_err++;
            end else begin
                want = exp_results.pop_front();
                if (got.st !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    n_err++;
                end
                if (got.addr !== want.addr) begin
                    $error("data_address: expected %h, got %h", want.addr, got.addr);
                    n_err++;
                end
                if (got.gb !== want.gb) begin
                    $error("granted_bytes: expected %0d, got %0d", want.gb, got.gb);
                    n_err++;
                end
            end
        end
        if (in_fire) begin
            c.act = s_axis_tuser;
            c.req = s_axis_tdata[24:0];
            c.addr = s_axis_tdata[72:25];
            exp_results.push_back(alloc_or_free(c));
            n_sent++;
        end
    end

    task automatic push_cmd(logic act, logic [24:0] req, logic [47:0] addr);
        t_cmd c;
        c.act = act;
        c.req = req;
        c.addr = addr;
        pend_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pend_cmds.size() > 0 || s_axis_tvalid || exp_results.size() > 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bfa_pkg::CFG_BASE) rg_base = val;
        else rg_size = val[24:0];
        table_rebuild();
    endtask

    // one random word, mostly small allocations and frees of live blocks
    task automatic random_cmd();
        int pick;
        logic [47:0] a;
        pick = $urandom_range(99);
        if (pick < 45) begin
            push_cmd(ACT_ALLOC, 25'($urandom_range(1, rg_size / 40 + 1)), 48'($urandom));
        end else if (pick < 52) begin
            push_cmd(ACT_ALLOC, 25'($urandom_range(0, 25'h1000000)),
                     48'({$urandom, $urandom}));
        end else if (pick < 88 && live_addrs.size() > 0) begin
            a = live_addrs[$urandom_range(live_addrs.size() - 1)];
            push_cmd(ACT_FREE, 25'($urandom), a);
        end else if (pick < 94 && live_addrs.size() > 0) begin
            a = live_addrs[$urandom_range(live_addrs.size() - 1)];
            push_cmd(ACT_FREE, '0, a + 48'($urandom_range(1, 40)));
        end else begin
            push_cmd(ACT_FREE, 25'($urandom), 48'({$urandom, $urandom}));
        end
    endtask

    task automatic random_phase(int n);
        repeat (n) begin
            while (pend_cmds.size() > 1) @(negedge i_clk);
            random_cmd();
        end
        wait_idle();
    endtask

    initial begin
        logic [47:0] a;
        rg_base = '0;
        rg_size = 25'd1048576;
        table_rebuild();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every status, double free, full-size grant
        push_cmd(ACT_ALLOC, 25'd0, '1);
        push_cmd(ACT_ALLOC, 25'h1000000, '0);
        push_cmd(ACT_ALLOC, 25'h0FFFFFF, '0);
        push_cmd(ACT_ALLOC, 25'd1, '0);
        push_cmd(ACT_ALLOC, 25'd33, '0);
        push_cmd(ACT_FREE, '1, 48'd32);
        push_cmd(ACT_FREE, '0, 48'd32);
        push_cmd(ACT_FREE, '0, '1);
        push_cmd(ACT_FREE, '0, '0);
        push_cmd(ACT_ALLOC, 25'd1048544, '0);
        push_cmd(ACT_FREE, '0, 48'd32);
        push_cmd(ACT_ALLOC, 25'd1048512, '0);
        push_cmd(ACT_ALLOC, 25'd1, '0);
        wait_idle();
        // fill the table so no split is possible
        repeat (70) push_cmd(ACT_ALLOC, 25'd16, '0);
        wait_idle();
        while (live_addrs.size() > 0) begin
            a = live_addrs[0];
            push_cmd(ACT_FREE, '0, a);
            wait_idle();
        end
        random_phase(380);

        // smallest region near the top of the address space, addresses wrap
        write_reg(bfa_pkg::CFG_BASE, 48'hFFFF_FFFF_FFE8);
        write_reg(bfa_pkg::CFG_SIZE, 48'd64);
        push_cmd(ACT_ALLOC, 25'd33, '0);
        push_cmd(ACT_ALLOC, 25'd32, '0);
        push_cmd(ACT_FREE, '0, 48'h8);
        random_phase(150);

        // largest region
        write_reg(bfa_pkg::CFG_BASE, 48'({$urandom, $urandom}));
        write_reg(bfa_pkg::CFG_SIZE, 48'h1000000);
        push_cmd(ACT_ALLOC, 25'h1000000 - 25'(HDR), '0);
        random_phase(400);

        // top base, small region
        write_reg(bfa_pkg::CFG_BASE, '1);
        write_reg(bfa_pkg::CFG_SIZE, 48'd4096);
        random_phase(400);

        // random settings
        write_reg(bfa_pkg::CFG_SIZE, 48'($urandom_range(64, 25'h1000000)));
        write_reg(bfa_pkg::CFG_BASE, 48'({$urandom, $urandom}));
        random_phase(400);

        repeat (200) @(negedge i_clk);
        if (n_err == 0 && exp_results.size() == 0) begin
            $display("best_fit_block_allocator_tb passed");
        end else begin
            $display("best_fit_block_allocator_tb failed");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("best_fit_block_allocator_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

### best_fit_block_allocator.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ram.sv
hw/rtl/best_fit_block_allocator.sv
tb/sv/best_fit_block_allocator_tb.sv
